### src/npcs_pkg.sv
// Shared types and constants for the nearest palette color search core.
// No dependencies; the cell, the core and the testbench import this package.
package npcs_pkg;

  localparam int ColorW = 8;
  localparam int IndexW = 8;
  // Widest squared RGB distance is 3 * 255 * 255 = 195075, 18 bits.
  localparam int DistW = 18;
  localparam logic [DistW-1:0] DistMax = 18'd195075;
  localparam logic [DistW-1:0] DistInit = '1;
  localparam logic [IndexW-1:0] TransparentIndex = 8'd255;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } npcs_op_t;

  // One beat as it travels down the chain of palette cells.
  typedef struct packed {
    logic              valid;
    npcs_op_t          opcode;
    logic [IndexW-1:0] entry_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              last;
    logic              transp;
    logic [DistW-1:0]  best_dist;
    logic [IndexW-1:0] best_idx;
  } npcs_lane_t;

endpackage

### src/npcs_if.sv
// Valid/ready channel interfaces for pixel/load beats in and index beats out.
// No dependencies.
interface npcs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, opcode, entry_index, red, green, blue, alpha, last_pixel,
                  input ready);
  modport sink (input valid, opcode, entry_index, red, green, blue, alpha, last_pixel,
                output ready);
endinterface

interface npcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  logic       last_out;

  modport source (output valid, color_index, last_out, input ready);
  modport sink (input valid, color_index, last_out, output ready);
endinterface

### src/npcs_cell.sv
// One palette cell: holds a single RGB entry, scores the passing pixel
// against it and keeps the running best. Depends on npcs_pkg.
module npcs_cell #(
  parameter logic [7:0] CELL_INDEX = 8'd0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  npcs_pkg::npcs_lane_t lane_in,
  output npcs_pkg::npcs_lane_t lane_out
);
  import npcs_pkg::*;

  logic [ColorW-1:0] ent_red;
  logic [ColorW-1:0] ent_green;
  logic [ColorW-1:0] ent_blue;
  npcs_lane_t        mid;
  logic [DistW-1:0]  mid_dist;
  logic [DistW-1:0]  dist_next;
  logic [ColorW-1:0] dr;
  logic [ColorW-1:0] dg;
  logic [ColorW-1:0] db;

  // Absolute channel differences and squared distance to the stored entry
  always_comb begin
    dr = (lane_in.red > ent_red) ? lane_in.red - ent_red : ent_red - lane_in.red;
    dg = (lane_in.green > ent_green) ? lane_in.green - ent_green : ent_green - lane_in.green;
    db = (lane_in.blue > ent_blue) ? lane_in.blue - ent_blue : ent_blue - lane_in.blue;
    dist_next = DistW'({{ColorW{1'b0}}, dr} * {{ColorW{1'b0}}, dr}) +
                DistW'({{ColorW{1'b0}}, dg} * {{ColorW{1'b0}}, dg}) +
                DistW'({{ColorW{1'b0}}, db} * {{ColorW{1'b0}}, db});
  end

  // Capture the entry when a load beat for this cell passes
  always_ff @(posedge clk) begin
    if (advance && lane_in.valid && lane_in.opcode == OP_WRITE &&
        lane_in.entry_index == CELL_INDEX) begin
      ent_red   <= lane_in.red;
      ent_green <= lane_in.green;
      ent_blue  <= lane_in.blue;
    end
  end

  // Stage one: hold the beat with its distance
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (advance) begin
      mid.valid <= lane_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mid.opcode      <= lane_in.opcode;
      mid.entry_index <= lane_in.entry_index;
      mid.red         <= lane_in.red;
      mid.green       <= lane_in.green;
      mid.blue        <= lane_in.blue;
      mid.last        <= lane_in.last;
      mid.transp      <= lane_in.transp;
      mid.best_dist   <= lane_in.best_dist;
      mid.best_idx    <= lane_in.best_idx;
      mid_dist        <= dist_next;
    end
  end

  // Stage two: replace the best only when strictly closer, so ties keep the lower index
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (advance) begin
      lane_out.valid <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lane_out.opcode      <= mid.opcode;
      lane_out.entry_index <= mid.entry_index;
      lane_out.red         <= mid.red;
      lane_out.green       <= mid.green;
      lane_out.blue        <= mid.blue;
      lane_out.last        <= mid.last;
      lane_out.transp      <= mid.transp;
      if (mid_dist < mid.best_dist) begin
        lane_out.best_dist <= mid_dist;
        lane_out.best_idx  <= CELL_INDEX;
      end else begin
        lane_out.best_dist <= mid.best_dist;
        lane_out.best_idx  <= mid.best_idx;
      end
    end
  end

endmodule

### src/nearest_palette_color_search_core.sv
// Nearest palette color search: a chain of PALETTE_ENTRIES palette cells, each holding one
// RGB entry, through which every beat flows in order. A load beat (opcode 0) is captured by
// the cell whose index it names and gives no result; a pixel beat (opcode 1) picks up the
// index of the nearest entry by exact squared RGB distance, lowest index on a tie, and gives
// one result. With alpha_mode set, a pixel of alpha zero returns 255. One beat is accepted
// every cycle unless the chain is halted; each cell takes two pipeline stages, and the
// output register follows the last cell. The whole chain halts only while the output
// register holds a result that is not taken. A pixel sees every load accepted before it;
// all entries must be loaded before the first pixel.
module nearest_palette_color_search_core #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  npcs_in_if.sink          pixels,
  npcs_out_if.source       results
);
  import npcs_pkg::*;

  logic       alpha_mode;
  logic       advance;
  npcs_lane_t lane [PALETTE_ENTRIES+1];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode <= 1'b0;
    end else if (cfg_we) begin
      alpha_mode <= cfg_wdata;
    end
  end

  // Move the chain unless a result is waiting in the output register
  assign advance      = !results.valid || results.ready;
  assign pixels.ready = advance;

  // Form the head beat with a fresh best
  always_comb begin
    lane[0].valid       = pixels.valid;
    lane[0].opcode      = npcs_op_t'(pixels.opcode);
    lane[0].entry_index = pixels.entry_index;
    lane[0].red         = pixels.red;
    lane[0].green       = pixels.green;
    lane[0].blue        = pixels.blue;
    lane[0].last        = pixels.last_pixel;
    lane[0].transp      = alpha_mode && (pixels.alpha == '0);
    lane[0].best_dist   = DistInit;
    lane[0].best_idx    = '0;
  end

  // Chain of palette cells
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    npcs_cell #(
      .CELL_INDEX (8'(k))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .lane_in  (lane[k]),
      .lane_out (lane[k+1])
    );
  end

  // Output register: keep pixel beats, drop load beats
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= lane[PALETTE_ENTRIES].valid &&
                       lane[PALETTE_ENTRIES].opcode == OP_CLASSIFY;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.color_index <= lane[PALETTE_ENTRIES].transp ? TransparentIndex
                                                          : lane[PALETTE_ENTRIES].best_idx;
      results.last_out    <= lane[PALETTE_ENTRIES].last;
    end
  end

`ifndef SYNTHESIS
  // A new result only comes from a pixel beat leaving the chain
  a_result_from_pixel: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(lane[PALETTE_ENTRIES].valid &&
                                   lane[PALETTE_ENTRIES].opcode == OP_CLASSIFY))
    else $error("result appeared without a pixel at the chain tail");

  // A searched pixel leaves with an index inside the palette
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (lane[PALETTE_ENTRIES].valid && lane[PALETTE_ENTRIES].opcode == OP_CLASSIFY &&
     !lane[PALETTE_ENTRIES].transp) |-> (32'(lane[PALETTE_ENTRIES].best_idx) < PALETTE_ENTRIES))
    else $error("best index outside the palette");

  // Every cell was scored, so the best distance left its initial value
  a_dist_scored: assert property (@(posedge clk) disable iff (rst)
    (lane[PALETTE_ENTRIES].valid && lane[PALETTE_ENTRIES].opcode == OP_CLASSIFY) |->
      (lane[PALETTE_ENTRIES].best_dist <= DistMax))
    else $error("best distance never updated along the chain");

  // The output register holds its result while the chain is halted
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=> (results.valid && $stable(results.color_index)))
    else $error("result changed while waiting");
`endif

endmodule

### tb/sv/nearest_palette_color_search_core_tb.sv
// Self-checking testbench for nearest_palette_color_search_core: loads the palette, classifies
// directed and random pixels over valid/ready channels and checks every index beat in order.
// Depends on npcs_pkg and the channel interfaces in npcs_if.sv.
module nearest_palette_color_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npcs_pkg::*;

  localparam int Entries = 256;
  // A beat crosses two stages per palette cell plus the output register.
  localparam int DrainCycles = 2 * Entries + 1 + 32;
  localparam int HoldCycles = 1000;
  localparam int WatchdogLimit = 5000;
  localparam int MaxGap = 6;
  localparam int CalmSpan = 64;
  localparam int Phase1Items = 300;
  localparam int Phase2Items = 100;
  localparam int Phase3Items = 120;
  localparam logic ModeRgb = 1'b0;
  localparam logic ModeRgba = 1'b1;

  typedef struct packed {
    npcs_op_t          opcode;
    logic [IndexW-1:0] entry_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] alpha;
    logic              last_pixel;
  } pixel_beat_t;

  typedef struct packed {
    logic [IndexW-1:0] color_index;
    logic              last_out;
  } index_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  npcs_in_if  pixels_bus ();
  npcs_out_if results_bus ();

  nearest_palette_color_search_core #(
    .PALETTE_ENTRIES(Entries)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pixels   (pixels_bus),
    .results  (results_bus)
  );

  // Shadow of the block: palette, mode and the indices still owed
  logic [23:0]  shadow_palette [Entries];
  logic         shadow_alpha_mode;
  index_beat_t  pending_indices [$];

  // Stimulus side: palette as the queued writes will leave it, and beats to send
  logic [23:0]  planned_palette [Entries];
  pixel_beat_t  beats_to_send [$];
  pixel_beat_t  offered_beat;

  int unsigned  in_wait;
  int unsigned  in_pops;
  logic         in_calm;
  int unsigned  out_wait;
  int unsigned  out_takes;
  logic         out_calm;
  int unsigned  squeeze_cycles;
  logic         squeeze_done;
  int unsigned  idle_cycles;
  int unsigned  mismatch_count;

  // Predict the index beat for one pixel
  function automatic index_beat_t nearest_index_of(pixel_beat_t b);
    index_beat_t res;
    int          best_dist;
    int          d;
    int          dr;
    int          dg;
    int          db;
    res.last_out = b.last_pixel;
    res.color_index = '0;
    if (shadow_alpha_mode && b.alpha == 8'd0) begin
      res.color_index = TransparentIndex;
    end else begin
      best_dist = 32'h7fffffff;
      for (int i = 0; i < Entries; i++) begin
        dr = int'(b.red) - int'(shadow_palette[i][23:16]);
        dg = int'(b.green) - int'(shadow_palette[i][15:8]);
        db = int'(b.blue) - int'(shadow_palette[i][7:0]);
        d = dr * dr + dg * dg + db * db;
        // Strictly closer only, so the lowest index keeps a tie
        if (d < best_dist) begin
          best_dist = d;
          res.color_index = IndexW'(i);
        end
      end
    end
    return res;
  endfunction

  // Apply one accepted beat to the shadow state
  task automatic apply_beat(pixel_beat_t b);
    if (b.opcode == OP_WRITE) begin
      if (int'(b.entry_index) < Entries) begin
        shadow_palette[b.entry_index] = {b.red, b.green, b.blue};
      end
    end else begin
      pending_indices = {pending_indices, nearest_index_of(b)};
    end
  endtask

  function automatic logic [7:0] random_component();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] random_color();
    return {random_component(), random_component(), random_component()};
  endfunction

  function automatic logic [7:0] random_alpha();
    return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic random_last();
    return ($urandom_range(0, 7) == 0);
  endfunction

  // Queue one beat and track the palette it leaves behind
  task automatic push_beat(npcs_op_t op, logic [7:0] idx, logic [23:0] rgb, logic [7:0] a,
                           logic last);
    pixel_beat_t b;
    b.opcode = op;
    b.entry_index = idx;
    b.red = rgb[23:16];
    b.green = rgb[15:8];
    b.blue = rgb[7:0];
    b.alpha = a;
    b.last_pixel = last;
    if (op == OP_WRITE && int'(idx) < Entries) planned_palette[idx] = rgb;
    beats_to_send = {beats_to_send, b};
  endtask

  // Queue a random beat: writes often copy an entry (ties), pixels often sit near one
  task automatic push_random(int write_pct);
    logic [23:0] rgb;
    logic [7:0]  idx;
    logic [23:0] base;
    int          pick;
    int          v;
    idx = 8'($urandom_range(0, 255));
    base = planned_palette[$urandom_range(0, Entries - 1)];
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < write_pct) begin
      rgb = (pick < 5) ? base : random_color();
      push_beat(OP_WRITE, idx, rgb, random_alpha(), random_last());
    end else begin
      if (pick < 2) begin
        rgb = base;
      end else if (pick < 6) begin
        for (int c = 0; c < 3; c++) begin
          v = int'(base[c*8 +: 8]) + $urandom_range(0, 8) - 4;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          rgb[c*8 +: 8] = 8'(v);
        end
      end else begin
        rgb = random_color();
      end
      push_beat(OP_CLASSIFY, idx, rgb, random_alpha(), random_last());
    end
  endtask

  // Wait until every beat is sent and answered, then let loads drain out of the chain
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || pixels_bus.valid || pending_indices.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_alpha_mode(logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_alpha_mode = mode;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sequence the phases
  initial begin
    logic [23:0] few_colors [6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    pixels_bus.valid = 1'b0;
    pixels_bus.opcode = OP_WRITE;
    pixels_bus.entry_index = '0;
    pixels_bus.red = '0;
    pixels_bus.green = '0;
    pixels_bus.blue = '0;
    pixels_bus.alpha = '0;
    pixels_bus.last_pixel = 1'b0;
    results_bus.ready = 1'b0;
    shadow_alpha_mode = ModeRgb;
    mismatch_count = 0;
    for (int i = 0; i < Entries; i++) begin
      shadow_palette[i] = '0;
      planned_palette[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // RGBA mode: full palette load, then directed cases
    write_alpha_mode(ModeRgba);
    @(negedge clk);
    for (int i = 0; i < Entries; i++) push_beat(OP_WRITE, 8'(i), random_color(), 8'd0, 1'b0);
    push_beat(OP_WRITE, 8'd0, 24'h000000, 8'd0, 1'b0);
    push_beat(OP_WRITE, 8'd255, 24'hffffff, 8'hff, 1'b1);
    push_beat(OP_WRITE, 8'd5, {8'd100, 8'd150, 8'd200}, 8'd0, 1'b0);
    // alpha and last are ignored on a load
    push_beat(OP_WRITE, 8'd9, {8'd100, 8'd150, 8'd200}, 8'd0, 1'b1);
    push_beat(OP_WRITE, 8'd3, {8'd30, 8'd10, 8'd10}, 8'd7, 1'b0);
    push_beat(OP_WRITE, 8'd7, {8'd10, 8'd10, 8'd10}, 8'd0, 1'b0);
    push_beat(OP_CLASSIFY, 8'd0, 24'h000000, 8'hff, 1'b0);
    push_beat(OP_CLASSIFY, 8'd255, 24'hffffff, 8'd1, 1'b1);
    push_beat(OP_CLASSIFY, 8'd17, {8'd100, 8'd150, 8'd200}, 8'd128, 1'b0);
    push_beat(OP_CLASSIFY, 8'd3, {8'd20, 8'd10, 8'd10}, 8'hff, 1'b0);
    push_beat(OP_CLASSIFY, 8'd0, 24'h000000, 8'd0, 1'b0);
    push_beat(OP_CLASSIFY, 8'd255, 24'hffffff, 8'd0, 1'b1);
    push_beat(OP_CLASSIFY, 8'd85, 24'hff00ff, 8'hff, 1'b0);
    push_beat(OP_CLASSIFY, 8'd170, 24'h00ff00, 8'd200, 1'b1);
    push_beat(OP_CLASSIFY, 8'd1, 24'h808080, 8'd1, 1'b0);
    push_beat(OP_CLASSIFY, 8'd2, {8'd101, 8'd150, 8'd200}, 8'hff, 1'b0);
    // A load is seen by the very next pixel: entry 5 leaves the tie, so the match now goes to entry 9
    push_beat(OP_WRITE, 8'd5, {8'd1, 8'd2, 8'd3}, 8'hff, 1'b1);
    push_beat(OP_CLASSIFY, 8'd5, {8'd100, 8'd150, 8'd200}, 8'd64, 1'b0);
    push_beat(OP_CLASSIFY, 8'd9, {8'd1, 8'd2, 8'd3}, 8'd255, 1'b1);
    for (int i = 0; i < Phase1Items; i++) push_random(20);
    wait_idle();

    // RGB mode: reload from a handful of colors so ties are everywhere
    write_alpha_mode(ModeRgb);
    @(negedge clk);
    for (int c = 0; c < 6; c++) few_colors[c] = random_color();
    for (int i = 0; i < Entries; i++) begin
      push_beat(OP_WRITE, 8'((i * 7) % Entries), few_colors[$urandom_range(0, 5)],
                random_alpha(), random_last());
    end
    push_beat(OP_CLASSIFY, 8'd0, few_colors[0], 8'd0, 1'b1);
    for (int i = 0; i < Phase2Items; i++) push_random(15);
    wait_idle();

    // Back to RGBA with a write-heavy mix
    write_alpha_mode(ModeRgba);
    @(negedge clk);
    for (int i = 0; i < Phase3Items; i++) push_random(40);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("nearest_palette_color_search_core: match");
    end else begin
      $display("nearest_palette_color_search_core: mismatch");
    end
    $finish;
  end

  // Drive pixel and load beats; no gaps until the output hold-off has ended
  always @(posedge clk) begin
    logic        offer;
    pixel_beat_t nxt;
    if (rst) begin
      pixels_bus.valid <= 1'b0;
      in_wait <= 0;
      in_pops = 0;
      in_calm = 1'b0;
    end else begin
      offer = pixels_bus.valid;
      if (pixels_bus.valid && pixels_bus.ready) begin
        apply_beat(offered_beat);
        offer = 1'b0;
      end
      if (!offer && in_wait != 0) begin
        in_wait <= in_wait - 1;
      end else if (!offer && beats_to_send.size() != 0) begin
        nxt = beats_to_send.pop_front();
        offered_beat <= nxt;
        pixels_bus.opcode <= nxt.opcode;
        pixels_bus.entry_index <= nxt.entry_index;
        pixels_bus.red <= nxt.red;
        pixels_bus.green <= nxt.green;
        pixels_bus.blue <= nxt.blue;
        pixels_bus.alpha <= nxt.alpha;
        pixels_bus.last_pixel <= nxt.last_pixel;
        offer = 1'b1;
        in_pops++;
        if (in_pops % CalmSpan == 0) in_calm = ($urandom_range(0, 3) == 0);
        in_wait <= (in_calm || !squeeze_done) ? 0 : $urandom_range(0, MaxGap);
      end
      pixels_bus.valid <= offer;
    end
  end

  // Take index beats and check them; hold off on the first one until the chain backs up
  always @(posedge clk) begin
    int unsigned w;
    index_beat_t want;
    if (rst) begin
      results_bus.ready <= 1'b0;
      out_wait <= 0;
      out_takes = 0;
      out_calm = 1'b0;
      squeeze_cycles = 0;
      squeeze_done = 1'b0;
    end else begin
      w = out_wait;
      if (results_bus.valid && results_bus.ready) begin
        if (pending_indices.size() == 0) begin
          $error("unexpected beat: color_index %0d, last_out %0b",
                 results_bus.color_index, results_bus.last_out);
          mismatch_count++;
        end else begin
          want = pending_indices.pop_front();
          if (results_bus.color_index !== want.color_index) begin
            $error("color_index: expected %0d, actual %0d",
                   want.color_index, results_bus.color_index);
            mismatch_count++;
          end
          if (results_bus.last_out !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out, results_bus.last_out);
            mismatch_count++;
          end
        end
        out_takes++;
        if (out_takes % CalmSpan == 0) out_calm = ($urandom_range(0, 3) == 0);
        w = out_calm ? 0 : $urandom_range(0, MaxGap);
      end else if (w != 0) begin
        w = w - 1;
      end
      if (!squeeze_done && results_bus.valid) begin
        squeeze_cycles++;
        if (squeeze_cycles >= HoldCycles) squeeze_done = 1'b1;
      end
      out_wait <= w;
      results_bus.ready <= squeeze_done && (w == 0);
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (pixels_bus.valid && pixels_bus.ready) ||
        (results_bus.valid && results_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("nearest_palette_color_search_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
